>>> src/blitter_word_datapath_defines.svh
// Assertion macros shared by the blitter word datapath checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BLITTER_WORD_DATAPATH_DEFINES_SVH
`define BLITTER_WORD_DATAPATH_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BWD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwd check failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define BWD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwd check failed: next-cycle implication");

`endif

>>> src/bwd_pkg.sv
// Package for the blitter word datapath: widths, register codes, shared types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bwd_pkg;

   localparam int WordW              = 16;
   localparam int RowW               = 11;
   localparam int IdxW               = 3;
   localparam int MaxRowWordsDefault = 2047;
   // Queue depth between front and back; must be a power of two.
   localparam int QueueDepth         = 2;

   // Bit positions inside control_zero.
   localparam int EnABit = 11;
   localparam int EnBBit = 10;
   localparam int EnCBit = 9;
   localparam int EnDBit = 8;

   // Bit positions inside control_one.
   localparam int FillExclBit = 4;
   localparam int FillInclBit = 3;
   localparam int FillCinBit  = 2;

   // Configuration register indexes.
   typedef enum logic [IdxW-1:0] {
      RegControlZero = 3'd0,
      RegControlOne  = 3'd1,
      RegFirstMask   = 3'd2,
      RegLastMask    = 3'd3,
      RegAHold       = 3'd4,
      RegBHold       = 3'd5,
      RegCHold       = 3'd6,
      RegRowWords    = 3'd7
   } bwd_reg_type;

   // Configuration seen by the front and back parts.
   typedef struct packed {
      logic [WordW-1:0] control_zero;
      logic [WordW-1:0] control_one;
      logic [WordW-1:0] first_mask;
      logic [WordW-1:0] last_mask;
      logic [WordW-1:0] a_hold;
      logic [WordW-1:0] b_hold;
      logic [WordW-1:0] c_hold;
      logic [RowW-1:0]  row_words;
   } bwd_cfg_type;

   // One classified word travelling from front to back.
   typedef struct packed {
      logic [WordW-1:0] a;
      logic [WordW-1:0] b;
      logic [WordW-1:0] c;
      logic             first;
      logic             last;
   } bwd_item_type;

endpackage

`default_nettype wire

>>> src/bwd_front.sv
// Front part of the blitter word datapath: accepts words, tracks the column,
// picks source or hold words and marks row first and last words. Uses bwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwd_front #(
   parameter int MAX_ROW_WORDS = bwd_pkg::MaxRowWordsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bwd_pkg::WordW-1:0]    req_a_word,
   input  logic [bwd_pkg::WordW-1:0]    req_b_word,
   input  logic [bwd_pkg::WordW-1:0]    req_c_word,
   input  logic                         req_first_word,
   input  bwd_pkg::bwd_cfg_type         cfg,
   input  logic                         q_full,
   output logic                         q_push,
   output bwd_pkg::bwd_item_type        q_item
);
   import bwd_pkg::*;

   localparam int ColW = $clog2(MAX_ROW_WORDS);
   localparam logic [RowW-1:0] MaxEff = RowW'(MAX_ROW_WORDS);

   logic [ColW-1:0] col_ff;
   logic [ColW-1:0] col_in;
   logic [RowW-1:0] eff_len;
   logic [RowW-1:0] col_ext;
   logic [RowW-1:0] col_cur;
   logic            restart;
   logic            last;

   // Effective row length: zero counts as one, clamp to the supported maximum.
   always_comb begin
      if (cfg.row_words == '0) begin
         eff_len = RowW'(1);
      end else if (cfg.row_words > MaxEff) begin
         eff_len = MaxEff;
      end else begin
         eff_len = cfg.row_words;
      end
   end

   // Column of this word; a new blit or a shortened row restarts at zero.
   always_comb begin
      col_ext = RowW'(col_ff);
      restart = req_first_word || (col_ext >= eff_len);
      col_cur = restart ? '0 : col_ext;
      last    = (col_cur == (eff_len - RowW'(1)));
      col_in  = last ? '0 : ColW'(col_cur + RowW'(1));
   end

   // Handshake with the queue.
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classified word: disabled channels take their hold words.
   always_comb begin
      q_item.a     = cfg.control_zero[EnABit] ? req_a_word : cfg.a_hold;
      q_item.b     = cfg.control_zero[EnBBit] ? req_b_word : cfg.b_hold;
      q_item.c     = cfg.control_zero[EnCBit] ? req_c_word : cfg.c_hold;
      q_item.first = (col_cur == '0);
      q_item.last  = last;
   end

   // Column counter advances on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (q_push) begin
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

>>> src/bwd_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Uses bwd_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bwd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bwd_pkg::bwd_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output bwd_pkg::bwd_item_type pop_item,
   output logic                  empty
);
   import bwd_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   bwd_item_type    entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   assign full     = (count_ff == CntW'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> src/bwd_back.sv
// Back part of the blitter word datapath: shift, mask, minterm and fill, with
// the result register facing the response channel. Uses bwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bwd_pkg::bwd_cfg_type      cfg,
   input  logic                      q_empty,
   input  bwd_pkg::bwd_item_type     q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bwd_pkg::WordW-1:0] rsp_d_word,
   output logic                      rsp_d_write,
   output logic                      rsp_row_end
);
   import bwd_pkg::*;

   logic [WordW-1:0]   prev_a_ff;
   logic [WordW-1:0]   prev_b_ff;
   logic               carry_ff;
   logic               rsp_valid_ff;
   logic [WordW-1:0]   d_word_ff;
   logic               d_write_ff;
   logic               row_end_ff;

   logic               take;
   logic [WordW-1:0]   prev_a;
   logic [WordW-1:0]   prev_b;
   logic               carry_start;
   logic [2*WordW-1:0] a_pair;
   logic [2*WordW-1:0] b_pair;
   logic [WordW-1:0]   a_aligned;
   logic [WordW-1:0]   a_trimmed;
   logic [WordW-1:0]   b_aligned;
   logic [WordW-1:0]   minterm_out;
   logic [WordW-1:0]   filled;
   logic               fill_incl;
   logic               fill_on;
   logic               carry_out;
   logic [WordW-1:0]   d_word_in;

   // Take a word when the result register is free or being drained.
   assign take  = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop = take;

   // Row start clears the previous words and reloads the fill carry.
   always_comb begin
      prev_a      = q_item.first ? '0 : prev_a_ff;
      prev_b      = q_item.first ? '0 : prev_b_ff;
      carry_start = q_item.first ? cfg.control_one[FillCinBit] : carry_ff;
   end

   // Barrel shift right, taking in bits of the previous word, then masks on A.
   always_comb begin
      a_pair    = {prev_a, q_item.a} >> cfg.control_zero[15:12];
      b_pair    = {prev_b, q_item.b} >> cfg.control_one[15:12];
      a_aligned = a_pair[WordW-1:0];
      b_aligned = b_pair[WordW-1:0];
      a_trimmed = a_aligned;
      if (q_item.first) begin
         a_trimmed = a_trimmed & cfg.first_mask;
      end
      if (q_item.last) begin
         a_trimmed = a_trimmed & cfg.last_mask;
      end
   end

   // Minterm: each result bit picks the minterm bit addressed by its A, B, C bits.
   always_comb begin
      for (int i = 0; i < WordW; i++) begin
         minterm_out[i] = cfg.control_zero[{a_trimmed[i], b_aligned[i], q_item.c[i]}];
      end
   end

   // Fill: the carry after bit i is the start carry xor the parity of bits 0..i.
   always_comb begin
      fill_incl = cfg.control_one[FillInclBit];
      fill_on   = fill_incl || cfg.control_one[FillExclBit];
      for (int i = 0; i < WordW; i++) begin
         filled[i] = (carry_start ^ (^(minterm_out & WordW'((32'd2 << i) - 32'd1))))
                     || (fill_incl && minterm_out[i]);
      end
      carry_out = carry_start ^ (^minterm_out);
      d_word_in = fill_on ? filled : minterm_out;
   end

   // Row state kept between words.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= '0;
         prev_b_ff <= '0;
         carry_ff  <= 1'b0;
      end else if (take) begin
         prev_a_ff <= q_item.a;
         prev_b_ff <= q_item.b;
         carry_ff  <= fill_on ? carry_out : carry_start;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         d_word_ff  <= d_word_in;
         d_write_ff <= cfg.control_zero[EnDBit];
         row_end_ff <= q_item.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_d_word  = d_word_ff;
   assign rsp_d_write = d_write_ff;
   assign rsp_row_end = row_end_ff;

endmodule

`default_nettype wire

>>> src/blitter_word_datapath.sv
// Top level of the blitter word datapath: register file, front, queue and back.
// Depends on bwd_pkg, bwd_front, bwd_queue and bwd_back.
// Path: an accepted word is written into the queue, then moves to the result register when taken.
// Throughput: one word per cycle while rsp_ready holds, set by the back stage and its row state.
// Stalls: the input is held off while the two-entry queue is full.
// Synchronous active-high reset empties queue, clears row and valid state, sets row_words to 1.
`timescale 1ns / 1ps
`default_nettype none

module blitter_word_datapath #(
   parameter int MAX_ROW_WORDS = bwd_pkg::MaxRowWordsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [bwd_pkg::WordW-1:0] req_a_word,
   input  logic [bwd_pkg::WordW-1:0] req_b_word,
   input  logic [bwd_pkg::WordW-1:0] req_c_word,
   input  logic                      req_first_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bwd_pkg::WordW-1:0] rsp_d_word,
   output logic                      rsp_d_write,
   output logic                      rsp_row_end,
   input  logic                      csr_wr_en,
   input  logic [bwd_pkg::IdxW-1:0]  csr_index,
   input  logic [bwd_pkg::WordW-1:0] csr_wdata
);
   import bwd_pkg::*;

   // Register values after reset: all zero except a one-word row.
   localparam bwd_cfg_type CfgReset = '{row_words: RowW'(1), default: '0};

   bwd_cfg_type  cfg_ff;
   bwd_cfg_type  cfg_in;
   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_empty;
   bwd_item_type push_item;
   bwd_item_type pop_item;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            RegControlZero: cfg_in.control_zero = csr_wdata;
            RegControlOne:  cfg_in.control_one  = csr_wdata;
            RegFirstMask:   cfg_in.first_mask   = csr_wdata;
            RegLastMask:    cfg_in.last_mask    = csr_wdata;
            RegAHold:       cfg_in.a_hold       = csr_wdata;
            RegBHold:       cfg_in.b_hold       = csr_wdata;
            RegCHold:       cfg_in.c_hold       = csr_wdata;
            RegRowWords:    cfg_in.row_words    = csr_wdata[RowW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify.
   bwd_front #(
      .MAX_ROW_WORDS(MAX_ROW_WORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_word     (req_a_word),
      .req_b_word     (req_b_word),
      .req_c_word     (req_c_word),
      .req_first_word (req_first_word),
      .cfg            (cfg_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   // Queue between the two parts.
   bwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // Back: compute and deliver.
   bwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_item      (pop_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_d_word  (rsp_d_word),
      .rsp_d_write (rsp_d_write),
      .rsp_row_end (rsp_row_end)
   );

endmodule

`default_nettype wire

>>> src/bwd_checker.sv
// Port-level checker for the blitter word datapath, bound to the top level.
// Depends on blitter_word_datapath_defines.svh for its assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "blitter_word_datapath_defines.svh"

module bwd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bwd_pkg::WordW-1:0] rsp_d_word,
   input logic                      rsp_d_write,
   input logic                      rsp_row_end
);
   import bwd_pkg::*;

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   // Words accepted but not yet delivered.
   always_comb begin
      pending_in = pending_ff;
      if (in_acc && !out_acc) begin
         pending_in = pending_ff + 3'd1;
      end else if (out_acc && !in_acc) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response is only shown for a word that was accepted.
   `BWD_ASSERT_IMP(a_no_invented_word, clock, reset, rsp_valid, pending_ff != 3'd0)
   // At most the queue plus the result register can be in flight.
   `BWD_ASSERT_IMP(a_bounded_pending, clock, reset, 1'b1, pending_ff <= 3'(QueueDepth + 1))
   // The input side stalls only when the queue holds its full depth.
   `BWD_ASSERT_IMP(a_stall_only_full, clock, reset, !req_ready, pending_ff >= 3'(QueueDepth))
   // A stalled response keeps its word.
   `BWD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_d_word) && $stable(rsp_d_write) && $stable(rsp_row_end))

endmodule

bind blitter_word_datapath bwd_checker u_bwd_checker (.*);

`default_nettype wire

>>> tb/tb_blitter_word_datapath.sv
// Self-checking testbench for blitter_word_datapath: directed and random words
// with random idling on both sides. Depends on bwd_pkg and blitter_word_datapath.
`timescale 1ns / 1ps

module tb_blitter_word_datapath;
   import bwd_pkg::*;

   localparam int MaxRow      = MaxRowWordsDefault;
   localparam int RandomWords = 1500;
   localparam int LongHold    = 100;
   localparam int QuietLimit  = 2000;
   localparam int SettleTicks = 4;

   // Channel enable groups, ordered {A, B, C, D}.
   localparam logic [3:0] EnAll  = 4'b1111;
   localparam logic [3:0] EnAbd  = 4'b1101;
   localparam logic [3:0] EnAd   = 4'b1001;

   // Minterm functions used by the directed tests.
   localparam logic [7:0] MintermCopyA = 8'hF0;
   localparam logic [7:0] MintermCopyC = 8'hAA;
   localparam logic [7:0] MintermAxorB = 8'h3C;

   typedef struct packed {
      logic [WordW-1:0] d_word;
      logic             d_write;
      logic             row_end;
   } d_word_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [WordW-1:0]  req_a_word = '0;
   logic [WordW-1:0]  req_b_word = '0;
   logic [WordW-1:0]  req_c_word = '0;
   logic              req_first_word = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WordW-1:0]  rsp_d_word;
   logic              rsp_d_write;
   logic              rsp_row_end;
   logic              csr_wr_en = 1'b0;
   logic [IdxW-1:0]   csr_index = '0;
   logic [WordW-1:0]  csr_wdata = '0;

   // Register image and row state of the predictor.
   bwd_cfg_type       model_cfg;
   logic [WordW-1:0]  prev_a_word;
   logic [WordW-1:0]  prev_b_word;
   logic              row_fill_carry;
   int                next_column;

   d_word_result_type expected_d_words[$];
   d_word_result_type oldest_d_word;
   logic [WordW-1:0]  csr_plan[8];
   int                mismatch_count = 0;
   int                words_sent = 0;
   int                quiet_cycles = 0;
   bit                sender_steady = 1'b0;

   // Receiver idling state.
   int                hold_requests = 0;
   int                hold_served = 0;
   int                stall_left = 0;
   int                steady_left = 0;
   int unsigned       ready_roll;

   blitter_word_datapath dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_a_word     (req_a_word),
      .req_b_word     (req_b_word),
      .req_c_word     (req_c_word),
      .req_first_word (req_first_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_d_word     (rsp_d_word),
      .rsp_d_write    (rsp_d_write),
      .rsp_row_end    (rsp_row_end),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   // Builds control_zero from the A shift, the channel enables and the minterm.
   function automatic logic [15:0] ctl_zero(input logic [3:0] a_shift,
                                            input logic [3:0] enables,
                                            input logic [7:0] minterm);
      return {a_shift, enables, minterm};
   endfunction

   // Builds control_one from the B shift and the fill controls.
   function automatic logic [15:0] ctl_one(input logic [3:0] b_shift, input logic excl,
                                           input logic incl, input logic carry_in);
      return {b_shift, 7'd0, excl, incl, carry_in, 2'd0};
   endfunction

   // Random 16-bit value with the all-zero and all-one extremes favored.
   function automatic logic [15:0] pick_word_value();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Sender gap: mostly none, some short, a few long.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sender_steady || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Mirrors one register write into the predictor's register image.
   function automatic void apply_reg_write(input bwd_reg_type idx, input logic [15:0] value);
      case (idx)
         RegControlZero: model_cfg.control_zero = value;
         RegControlOne:  model_cfg.control_one  = value;
         RegFirstMask:   model_cfg.first_mask   = value;
         RegLastMask:    model_cfg.last_mask    = value;
         RegAHold:       model_cfg.a_hold       = value;
         RegBHold:       model_cfg.b_hold       = value;
         RegCHold:       model_cfg.c_hold       = value;
         RegRowWords:    model_cfg.row_words    = value[RowW-1:0];
         default: ;
      endcase
   endfunction

   // Computes the D word for one source word and advances the row state.
   function automatic d_word_result_type predict_d_word(input logic [15:0] a_in,
                                                        input logic [15:0] b_in,
                                                        input logic [15:0] c_in,
                                                        input logic first);
      d_word_result_type result;
      int               row_len;
      logic             row_start;
      logic             at_end;
      logic [15:0]      a_src, b_src, c_src, a_aligned, b_aligned, mixed, filled;
      logic [31:0]      joined;
      logic [7:0]       minterm;
      logic             carry;
      row_len = int'(model_cfg.row_words);
      if (row_len == 0) row_len = 1;
      if (row_len > MaxRow) row_len = MaxRow;
      if (first || next_column >= row_len) next_column = 0;
      row_start = (next_column == 0);
      if (row_start) begin
         prev_a_word = '0;
         prev_b_word = '0;
         row_fill_carry = model_cfg.control_one[FillCinBit];
      end

      // Disabled channels take their hold registers.
      a_src = model_cfg.control_zero[EnABit] ? a_in : model_cfg.a_hold;
      b_src = model_cfg.control_zero[EnBBit] ? b_in : model_cfg.b_hold;
      c_src = model_cfg.control_zero[EnCBit] ? c_in : model_cfg.c_hold;

      // Shift right, pulling bits in from the previous word of the row.
      joined = {prev_a_word, a_src} >> model_cfg.control_zero[15:12];
      a_aligned = joined[15:0];
      joined = {prev_b_word, b_src} >> model_cfg.control_one[15:12];
      b_aligned = joined[15:0];
      prev_a_word = a_src;
      prev_b_word = b_src;

      at_end = (next_column == row_len - 1);
      if (row_start) a_aligned = a_aligned & model_cfg.first_mask;
      if (at_end) a_aligned = a_aligned & model_cfg.last_mask;

      // Each output bit selects one minterm bit by its A, B, C bits.
      minterm = model_cfg.control_zero[7:0];
      for (int i = 0; i < WordW; i++) mixed[i] = minterm[{a_aligned[i], b_aligned[i], c_src[i]}];

      // Fill scans upward; every set source bit toggles the carry.
      if (model_cfg.control_one[FillInclBit] || model_cfg.control_one[FillExclBit]) begin
         carry = row_fill_carry;
         for (int i = 0; i < WordW; i++) begin
            if (mixed[i]) carry = ~carry;
            filled[i] = carry | (model_cfg.control_one[FillInclBit] & mixed[i]);
         end
         row_fill_carry = carry;
         mixed = filled;
      end

      next_column = at_end ? 0 : next_column + 1;
      result.d_word = mixed;
      result.d_write = model_cfg.control_zero[EnDBit];
      result.row_end = at_end;
      return result;
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // Offers one word, waits for the handshake and records its expected result.
   task automatic send_word(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic first);
      int gap;
      req_valid <= 1'b1;
      req_a_word <= a;
      req_b_word <= b;
      req_c_word <= c;
      req_first_word <= first;
      do @(posedge clock); while (!req_ready);
      expected_d_words.push_back(predict_d_word(a, b, c, first));
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected word has come back.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_d_words.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   // Writes all eight registers once the block is idle.
   task automatic configure(input logic [15:0] ctl0, input logic [15:0] ctl1,
                            input logic [15:0] first_mask, input logic [15:0] last_mask,
                            input logic [15:0] a_hold, input logic [15:0] b_hold,
                            input logic [15:0] c_hold, input logic [15:0] row_words);
      wait_for_idle();
      csr_plan[RegControlZero] = ctl0;
      csr_plan[RegControlOne]  = ctl1;
      csr_plan[RegFirstMask]   = first_mask;
      csr_plan[RegLastMask]    = last_mask;
      csr_plan[RegAHold]       = a_hold;
      csr_plan[RegBHold]       = b_hold;
      csr_plan[RegCHold]       = c_hold;
      csr_plan[RegRowWords]    = row_words;
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= bwd_reg_type'(i);
         csr_wdata <= csr_plan[i];
         @(posedge clock);
         apply_reg_write(bwd_reg_type'(i), csr_plan[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Registers at their reset values: every channel reads a zero hold word.
   task automatic test_reset_state();
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
   endtask

   // Each single-term minterm on patterns that hold all eight A, B, C combinations.
   task automatic test_minterm_functions();
      for (int k = 0; k < 8; k++) begin
         configure(ctl_zero(4'd0, EnAll, 8'(1 << k)), ctl_one(4'd0, 1'b0, 1'b0, 1'b0),
                   16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'd1);
         send_word(16'hFF00, 16'hF0F0, 16'hCCCC, 1'b1);
      end
   endtask

   // Largest shifts across a three-word row, with distinct first and last masks.
   task automatic test_shift_and_masks();
      configure(ctl_zero(4'd15, EnAbd, MintermAxorB), ctl_one(4'd15, 1'b0, 1'b0, 1'b0),
                16'h0FF0, 16'hF00F, 16'h5A5A, 16'hA5A5, 16'h1234, 16'd3);
      send_word(16'hFFFF, 16'h8001, 16'hFFFF, 1'b1);
      send_word(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      send_word(16'h8001, 16'h0000, 16'hFFFF, 1'b0);
   endtask

   // Inclusive, exclusive and both fill bits, with the carry crossing a word.
   task automatic test_fill_modes();
      configure(ctl_zero(4'd0, EnAd, MintermCopyA), ctl_one(4'd0, 1'b0, 1'b1, 1'b0),
                16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'd2);
      send_word(16'h0101, 16'h0, 16'h0, 1'b1);
      send_word(16'h8000, 16'h0, 16'h0, 1'b0);
      configure(ctl_zero(4'd0, EnAd, MintermCopyA), ctl_one(4'd0, 1'b1, 1'b0, 1'b1),
                16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'd2);
      send_word(16'h0101, 16'h0, 16'h0, 1'b1);
      send_word(16'h8000, 16'h0, 16'h0, 1'b0);
      configure(ctl_zero(4'd0, EnAd, MintermCopyA), ctl_one(4'd0, 1'b1, 1'b1, 1'b0),
                16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'd2);
      send_word(16'h0101, 16'h0, 16'h0, 1'b1);
      send_word(16'h8000, 16'h0, 16'h0, 1'b0);
   endtask

   // A zero row length acts as one word; the all-ones write gives the longest row.
   task automatic test_row_length_limits();
      configure(ctl_zero(4'd3, EnAll, MintermCopyC), ctl_one(4'd5, 1'b0, 1'b0, 1'b0),
                16'hFFFF, 16'h0F0F, 16'h0, 16'h0, 16'h0, 16'hF800);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
      configure(ctl_zero(4'd3, EnAll, MintermAxorB), ctl_one(4'd5, 1'b0, 1'b0, 1'b0),
                16'hFFFF, 16'h0F0F, 16'h0, 16'h0, 16'h0, 16'hFFFF);
      send_word(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
      send_word(16'h1234, 16'hFFFF, 16'h0000, 1'b0);
   endtask

   // Shortening the row mid-row: the next word restarts at column zero.
   task automatic test_column_out_of_range();
      configure(ctl_zero(4'd4, EnAll, MintermAxorB), ctl_one(4'd8, 1'b0, 1'b1, 1'b1),
                16'h00FF, 16'hFF00, 16'h0, 16'h0, 16'h0, 16'd4);
      send_word(16'hF00F, 16'h0FF0, 16'h0, 1'b1);
      send_word(16'h1234, 16'h5678, 16'h0, 1'b0);
      send_word(16'h9ABC, 16'hDEF0, 16'h0, 1'b0);
      configure(ctl_zero(4'd4, EnAll, MintermAxorB), ctl_one(4'd8, 1'b0, 1'b1, 1'b1),
                16'h00FF, 16'hFF00, 16'h0, 16'h0, 16'h0, 16'd2);
      send_word(16'h8421, 16'h1248, 16'h0, 1'b0);
      send_word(16'hFFFF, 16'h0001, 16'h0, 1'b0);
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_output_backpressure();
      configure(ctl_zero(4'd7, EnAll, 8'h96), ctl_one(4'd9, 1'b1, 1'b0, 1'b1),
                16'hF0FF, 16'hFF0F, 16'h0, 16'h0, 16'h0, 16'd5);
      sender_steady = 1'b1;
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 24; k++)
         send_word(pick_word_value(), pick_word_value(), pick_word_value(), k == 0);
      sender_steady = 1'b0;
      wait_for_idle();
   endtask

   // Random settings, each followed by a burst of mostly well-formed rows.
   task automatic test_random_blits();
      int          row_len;
      int          burst;
      logic [10:0] row_field;
      bit          start_blit;
      logic        first;
      int unsigned roll;
      while (words_sent < RandomWords) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) row_field = 11'd0;
         else if (roll == 1) row_field = 11'(MaxRow);
         else if (roll < 5) row_field = 11'($urandom_range(9, 64));
         else row_field = 11'($urandom_range(1, 8));
         configure(pick_word_value(), pick_word_value(), pick_word_value(), pick_word_value(),
                   pick_word_value(), pick_word_value(), pick_word_value(),
                   {5'($urandom), row_field});
         row_len = (row_field == 11'd0) ? 1 : int'(row_field);
         if (row_len > 64) begin
            burst = $urandom_range(20, 60);
         end else begin
            burst = row_len * $urandom_range(1, 4);
            if (burst > 64) burst = 64;
            // Some bursts stop inside a row so the next setting continues it.
            if ($urandom_range(0, 5) == 0) burst = burst - $urandom_range(0, row_len - 1);
            if (burst < 1) burst = 1;
         end
         start_blit = ($urandom_range(0, 6) != 0);
         sender_steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) hold_requests <= hold_requests + 1;
         for (int k = 0; k < burst; k++) begin
            first = (k == 0) && start_blit;
            if ($urandom_range(0, 11) == 0) first = 1'($urandom_range(0, 1));
            send_word(pick_word_value(), pick_word_value(), pick_word_value(), first);
         end
         sender_steady = 1'b0;
      end
   endtask

   // Receiver: random stalls and steady stretches, plus long holds on request.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         stall_left <= LongHold;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (steady_left > 0) begin
         steady_left <= steady_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 8) begin
            steady_left <= $urandom_range(20, 120);
            rsp_ready <= 1'b1;
         end else if (ready_roll < 28) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Each accepted word is compared with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_d_words.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_d_word, 16'h0);
         end else begin
            oldest_d_word = expected_d_words.pop_front();
            if (rsp_d_word !== oldest_d_word.d_word)
               report_mismatch("d_word", rsp_d_word, oldest_d_word.d_word);
            if (rsp_d_write !== oldest_d_word.d_write)
               report_mismatch("d_write", 16'(rsp_d_write), 16'(oldest_d_word.d_write));
            if (rsp_row_end !== oldest_d_word.row_end)
               report_mismatch("row_end", 16'(rsp_row_end), 16'(oldest_d_word.row_end));
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("Timeout: no word moved for %0d cycles", QuietLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      model_cfg = '0;
      model_cfg.row_words = 11'd1;
      prev_a_word = '0;
      prev_b_word = '0;
      row_fill_carry = 1'b0;
      next_column = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_minterm_functions();
      test_shift_and_masks();
      test_fill_modes();
      test_row_length_limits();
      test_column_out_of_range();
      test_output_backpressure();
      test_random_blits();
      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
